/* rtl/esort_pkg.sv */
// Shared types and constants for the exchange sort block.
`timescale 1ns / 1ps
`default_nettype none
package esort_pkg;

  // element width is fixed by the data format
  localparam int unsigned DataW        = 32;
  // default store depth
  localparam int unsigned DefaultDepth = 16;

  typedef logic signed [DataW-1:0] elem_t;

  typedef enum logic [2:0] {
    ST_LOAD,      // collecting elements
    ST_SORT_LD,   // first pass: fetch slot 0
    ST_SORT_LDW,  // latch slot i, fetch slot j
    ST_SORT_CMP,  // compare slot i with slot j
    ST_SORT_WB,   // write slot i back, fetch next slot i
    ST_EMIT_RD,   // fetch slot k for output
    ST_EMIT_OUT   // hand slot k to the output register
  } state_e;

endpackage
`default_nettype wire

/* rtl/esort_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module esort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/esort_cmp.sv */
// Shared compare-exchange unit: signed compare and swap select.
`timescale 1ns / 1ps
`default_nettype none
module esort_cmp import esort_pkg::*; (
  input  wire elem_t cur_i,        // value held for slot i
  input  wire elem_t cand_i,       // value read from slot j
  input  wire logic  descending_i,
  output logic       swap_o,
  output elem_t      keep_o,       // new value for slot i
  output elem_t      spill_o       // value to write to slot j
);

  always_comb begin
    swap_o  = descending_i ? (cand_i > cur_i) : (cur_i > cand_i);
    keep_o  = swap_o ? cand_i : cur_i;
    spill_o = cur_i;
  end

endmodule
`default_nettype wire

/* rtl/exchange_sort_with_order_core.sv */
// Top level of the exchange sort block: load, sort and emit sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Collects signed 32-bit elements, one per input transaction, into a store of
// DEPTH words until a transaction with last_in_i set arrives; elements beyond
// DEPTH are dropped and every result of that set carries overflow_o. The set is
// then sorted in place by exchange sort (slot i against every later slot j)
// and sent out in order, the final result with last_out_o set. The order comes
// from the one configuration bit: 0 ascending, 1 descending; write it only
// while the block is idle. The sort compares one slot pair at a time through the
// single compare-exchange unit and the single read port of the store. Each
// result is then read from the store and loaded into the output register,
// which out_stall_i can hold. The input is stalled from the last element until
// the final result has been loaded into the output register; the next set can
// start loading while that result waits.
module exchange_sort_with_order_core import esort_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_sort_descending_i,
  // input channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic signed [DataW-1:0] value_i,
  input  wire logic             last_in_i,
  // output channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic signed [DataW-1:0] sorted_value_o,
  output logic                  last_out_o,
  output logic                  overflow_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] CntDepth = CntW'(DEPTH);
  localparam logic [CntW-1:0] CntOne   = CntW'(1);
  localparam logic [CntW-1:0] CntTwo   = CntW'(2);

  state_e state_q, state_d;

  logic            desc_q;
  logic [CntW-1:0] count_q, count_d;   // stored elements of current set
  logic            ovf_q, ovf_d;       // an element of this set was dropped
  logic [IdxW-1:0] i_q, i_d;           // outer slot
  logic [IdxW-1:0] j_q, j_d;           // inner slot
  logic [IdxW-1:0] k_q, k_d;           // emit slot
  elem_t           cur_q, cur_d;       // running value of slot i

  // output register
  logic  out_valid_q, out_valid_d;
  elem_t out_value_q;
  logic  out_last_q;
  logic  out_ovf_q;
  logic  out_load;
  logic  out_free;

  // store ports
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  elem_t           ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  logic [DataW-1:0] ram_rdata;
  elem_t           rd_elem;

  // compare-exchange unit
  logic  cmp_swap;
  elem_t cmp_keep;
  elem_t cmp_spill;

  logic            in_fire;
  logic [CntW-1:0] cnt_last;
  logic            j_at_end;
  logic            more_passes;
  logic            k_at_end;

  assign cfg_ready_o    = 1'b1;
  assign in_stall_o     = (state_q != ST_LOAD);
  assign in_fire        = in_valid_i && !in_stall_o;
  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_out_o     = out_last_q;
  assign overflow_o     = out_ovf_q;
  assign out_free       = !out_valid_q || !out_stall_i;

  assign rd_elem     = elem_t'(ram_rdata);
  assign cnt_last    = count_q - CntOne;
  assign j_at_end    = (CntW'(j_q) == cnt_last);
  // another pass remains if the next slot i is still below n-1
  assign more_passes = ((CntW'(i_q) + CntOne) < cnt_last);
  assign k_at_end    = (CntW'(k_q) == cnt_last);

  esort_ram #(
    .WIDTH (DataW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  esort_cmp u_cmp (
    .cur_i        (cur_q),
    .cand_i       (rd_elem),
    .descending_i (desc_q),
    .swap_o       (cmp_swap),
    .keep_o       (cmp_keep),
    .spill_o      (cmp_spill)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire && last_in_i) begin
          state_d = (count_d >= CntTwo) ? ST_SORT_LD : ST_EMIT_RD;
        end
      end
      ST_SORT_LD:  state_d = ST_SORT_LDW;
      ST_SORT_LDW: state_d = ST_SORT_CMP;
      ST_SORT_CMP: begin
        if (j_at_end) begin
          state_d = ST_SORT_WB;
        end
      end
      ST_SORT_WB:  state_d = more_passes ? ST_SORT_LDW : ST_EMIT_RD;
      ST_EMIT_RD:  state_d = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_free) begin
          state_d = k_at_end ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default:     state_d = ST_LOAD;
    endcase
  end

  // datapath and store control
  always_comb begin
    count_d   = count_q;
    ovf_d     = ovf_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    cur_d     = cur_q;
    ram_we    = 1'b0;
    ram_waddr = i_q;
    ram_wdata = cur_q;
    ram_raddr = i_q;
    out_load  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        k_d = '0;
        if (in_fire) begin
          if (count_q < CntDepth) begin
            ram_we    = 1'b1;
            ram_waddr = IdxW'(count_q);
            ram_wdata = value_i;
            count_d   = count_q + CntOne;
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      ST_SORT_LD: begin
        ram_raddr = '0;
        i_d       = '0;
        j_d       = IdxW'(1);
      end
      ST_SORT_LDW: begin
        cur_d     = rd_elem;
        ram_raddr = j_q;
      end
      ST_SORT_CMP: begin
        // slot j gets the old slot i value when the pair is out of order
        ram_we    = cmp_swap;
        ram_waddr = j_q;
        ram_wdata = cmp_spill;
        cur_d     = cmp_keep;
        ram_raddr = j_q + IdxW'(1);
        if (!j_at_end) begin
          j_d = j_q + IdxW'(1);
        end
      end
      ST_SORT_WB: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = cur_q;
        ram_raddr = i_q + IdxW'(1);
        i_d       = i_q + IdxW'(1);
        j_d       = i_q + IdxW'(2);
      end
      ST_EMIT_RD: begin
        ram_raddr = k_q;
      end
      ST_EMIT_OUT: begin
        ram_raddr = k_q;
        if (out_free) begin
          out_load = 1'b1;
          if (k_at_end) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end else begin
            k_d = k_q + IdxW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      desc_q      <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        desc_q <= cfg_sort_descending_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (out_load) begin
      out_value_q <= rd_elem;
      out_last_q  <= k_at_end;
      out_ovf_q   <= ovf_q;
    end
  end

endmodule
`default_nettype wire

/* bench/exchange_sort_with_order_checker.sv */
// Checker for the exchange sort block: predicts sorted sets and compares results.
`timescale 1ns / 1ps
module exchange_sort_with_order_checker import esort_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic        cfg_sort_descending_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire elem_t       value_i,
  input  wire logic        last_in_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire elem_t       sorted_value_i,
  input  wire logic        last_out_i,
  input  wire logic        overflow_i,
  input  wire logic        final_check_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  typedef struct packed {
    elem_t value;
    logic  last;
    logic  overflow;
  } sorted_elem_t;

  sorted_elem_t sorted_q[$];
  elem_t        held_set[DEPTH];
  int unsigned  held_count;
  logic         dropped_any;
  logic         descending;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    fail_count_o++;
  endtask

  // store one element; on last, sort the held set and queue its results
  task automatic absorb_element(input elem_t v, input logic last);
    elem_t        tmp;
    sorted_elem_t res;
    int unsigned  i;
    int unsigned  j;
    if (held_count < DEPTH) begin
      held_set[held_count] = v;
      held_count++;
    end else begin
      dropped_any = 1'b1;
    end
    if (last) begin
      for (i = 0; i + 1 < held_count; i++) begin
        for (j = i + 1; j < held_count; j++) begin
          if (descending ? (held_set[j] > held_set[i]) : (held_set[i] > held_set[j])) begin
            tmp         = held_set[i];
            held_set[i] = held_set[j];
            held_set[j] = tmp;
          end
        end
      end
      for (i = 0; i < held_count; i++) begin
        res.value    = held_set[i];
        res.last     = (i + 1 == held_count);
        res.overflow = dropped_any;
        sorted_q.push_back(res);
      end
      held_count  = 0;
      dropped_any = 1'b0;
    end
  endtask

  task automatic check_result();
    sorted_elem_t exp;
    if (sorted_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result value %0d", sorted_value_i));
    end else begin
      exp = sorted_q.pop_front();
      if (sorted_value_i !== exp.value)
        report_mismatch($sformatf("sorted_value %0d, expected %0d", sorted_value_i, exp.value));
      if (last_out_i !== exp.last)
        report_mismatch($sformatf("last_out %b, expected %b", last_out_i, exp.last));
      if (overflow_i !== exp.overflow)
        report_mismatch($sformatf("overflow %b, expected %b", overflow_i, exp.overflow));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count   = 0;
      dropped_any  = 1'b0;
      descending   = 1'b0;
      fail_count_o = 0;
      sorted_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) descending = cfg_sort_descending_i;
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) absorb_element(value_i, last_in_i);
      if (final_check_i && sorted_q.size() != 0) begin
        report_mismatch($sformatf("%0d expected results never arrived", sorted_q.size()));
        sorted_q.delete();
      end
    end
    pending_o = sorted_q.size();
  end

endmodule

/* bench/exchange_sort_with_order_core_test.sv */
// Testbench top for the exchange sort block: stimulus, receiver, watchdog, verdict.
`timescale 1ns / 1ps
module exchange_sort_with_order_core_test;
  import esort_pkg::*;

  localparam int unsigned DEPTH        = DefaultDepth;
  // cycles with no transaction on any channel before the run is abandoned;
  // covers a full 16-element sort, the long hold-off and gaps
  localparam int unsigned IDLE_LIMIT   = 4000;
  // long receiver hold-off, long enough to back the input up
  localparam int unsigned HOLD_CYCLES  = 400;
  // quiet cycles after the last result before a register write / the verdict
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned TAIL         = 40;
  localparam int unsigned PHASE_ITEMS  = 140;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_sort_descending_i;
  logic        in_valid_i;
  logic        in_stall_o;
  elem_t       value_i;
  logic        last_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  elem_t       sorted_value_o;
  logic        last_out_o;
  logic        overflow_o;
  logic        final_check;
  int unsigned fail_count;
  int unsigned pending;

  // idling control for sender and receiver, and the watchdog count
  logic        calm;
  logic        hold_req;
  logic        hold_taken;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  exchange_sort_with_order_core #(.DEPTH(DEPTH)) i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_sort_descending_i (cfg_sort_descending_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .value_i               (value_i),
    .last_in_i             (last_in_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .sorted_value_o        (sorted_value_o),
    .last_out_o            (last_out_o),
    .overflow_o            (overflow_o)
  );

  exchange_sort_with_order_checker #(.DEPTH(DEPTH)) i_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_i           (cfg_ready_o),
    .cfg_sort_descending_i (cfg_sort_descending_i),
    .in_valid_i            (in_valid_i),
    .in_stall_i            (in_stall_o),
    .value_i               (value_i),
    .last_in_i             (last_in_i),
    .out_valid_i           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .sorted_value_i        (sorted_value_o),
    .last_out_i            (last_out_o),
    .overflow_i            (overflow_o),
    .final_check_i         (final_check),
    .fail_count_o          (fail_count),
    .pending_o             (pending)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Receiver: stalls about 24% of cycles, never while calm. One long hold-off
  // on request, counted here, so the block fills and stalls its input.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else if (hold_req && !hold_taken) begin
      hold_taken  = 1'b1;
      hold_left   = HOLD_CYCLES - 1;
      out_stall_i = 1'b1;
    end else if (calm) begin
      out_stall_i = 1'b0;
    end else begin
      out_stall_i = ($urandom_range(99) < 24);
    end
  end

  // Watchdog: counts cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("** exchange_sort_with_order_core: FAILED **");
        $finish;
      end
    end
  end

  // One element transaction. Valid goes low only for a random gap; the
  // payload holds while stalled.
  task automatic send_element(input elem_t v, input logic last);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 24) gap = $urandom_range(1, 4);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    value_i    = v;
    last_in_i  = last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic end_input();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // register write, only while idle
  task automatic write_order(input logic descending);
    @(negedge clk_i);
    cfg_valid_i           = 1'b1;
    cfg_sort_descending_i = descending;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // all results back, then a short settle
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // mix of full-range, clustered (duplicates) and extreme values
  function automatic elem_t pick_value();
    case ($urandom_range(3))
      0, 1:    return elem_t'($urandom());
      2:       return elem_t'($urandom_range(8)) - elem_t'(4);
      default: begin
        case ($urandom_range(3))
          0:       return elem_t'(32'h7fff_ffff);
          1:       return elem_t'(32'h8000_0000);
          2:       return elem_t'(0);
          default: return elem_t'(-1);
        endcase
      end
    endcase
  endfunction

  // Whole sets with random content; about one in ten overruns the store.
  task automatic send_random_sets(input int unsigned items);
    int unsigned sent;
    int unsigned set_len;
    int unsigned k;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) set_len = $urandom_range(DEPTH + 1, DEPTH + 6);
      else                        set_len = $urandom_range(1, DEPTH);
      for (k = 0; k < set_len; k++) send_element(pick_value(), k + 1 == set_len);
      sent += set_len;
    end
  endtask

  initial begin
    int unsigned k;
    rst_ni                = 1'b0;
    cfg_valid_i           = 1'b0;
    cfg_sort_descending_i = 1'b0;
    in_valid_i            = 1'b0;
    value_i               = '0;
    last_in_i             = 1'b0;
    out_stall_i           = 1'b0;
    final_check           = 1'b0;
    calm                  = 1'b0;
    hold_req              = 1'b0;
    hold_taken            = 1'b0;
    hold_left             = 0;
    quiet_cycles          = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, ascending
    write_order(1'b0);
    // single-element set at the top of the range
    send_element(elem_t'(32'h7fff_ffff), 1'b1);
    // extremes, signs and a duplicate pair
    send_element(elem_t'(32'h8000_0000), 1'b0);
    send_element(elem_t'(32'h7fff_ffff), 1'b0);
    send_element(elem_t'(-1), 1'b0);
    send_element(elem_t'(0), 1'b0);
    send_element(elem_t'(1), 1'b0);
    send_element(elem_t'(5), 1'b0);
    send_element(elem_t'(5), 1'b1);
    // store overrun: DEPTH kept, one dropped, every result flagged
    for (k = 0; k <= DEPTH; k++)
      send_element(elem_t'(32'h5555_5555) ^ elem_t'(k * 32'h1357_9bdf), k == DEPTH);
    end_input();
    wait_drained();

    // random, descending, with idling on both sides
    write_order(1'b1);
    send_random_sets(PHASE_ITEMS);
    end_input();
    wait_drained();

    // random, ascending, no idling
    write_order(1'b0);
    calm = 1'b1;
    send_random_sets(PHASE_ITEMS);
    end_input();
    wait_drained();
    calm = 1'b0;

    // random, descending, receiver holds off for a long stretch meanwhile
    write_order(1'b1);
    hold_req = 1'b1;
    send_random_sets(PHASE_ITEMS);
    end_input();

    do @(posedge clk_i); while (pending != 0);
    repeat (TAIL) @(posedge clk_i);
    @(negedge clk_i);
    final_check = 1'b1;
    @(negedge clk_i);
    final_check = 1'b0;
    if (fail_count == 0) begin
      $display("** exchange_sort_with_order_core: PASSED **");
    end else begin
      $display("** exchange_sort_with_order_core: FAILED **");
    end
    $finish;
  end

endmodule
